[hw/rtl/ltip_pkg.sv]
// Shared types and constants for the label trace interpolator.
package ltip_pkg;

    localparam int LABEL_COUNT = 1024;
    localparam int LABEL_W     = $clog2(LABEL_COUNT);
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 7;
    localparam int MAX_STEPS   = 64;
    localparam int REM_W       = STEP_W;
    localparam int DIV_CNT_W   = $clog2(COORD_W);

    // -1.0 in Q16.16
    localparam logic [COORD_W-1:0] MISSING_COORD = 32'hFFFF_0000;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRACE = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } entry_t;

    typedef struct packed {
        logic               en;
        logic [LABEL_W-1:0] addr;
        entry_t             data;
    } tbl_wr_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W:0]   dividend;
        logic [STEP_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic [COORD_W-1:0]        quotient;
    } div_rsp_t;

endpackage

[hw/rtl/ltip_if.sv]
// Handshake channels: command transactions in, trace point transactions out.
interface ltip_cmd_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [ltip_pkg::LABEL_W-1:0]       first_label;
    logic [ltip_pkg::LABEL_W-1:0]       second_label;
    logic signed [ltip_pkg::COORD_W-1:0] coord_x;
    logic signed [ltip_pkg::COORD_W-1:0] coord_y;
    logic signed [ltip_pkg::COORD_W-1:0] coord_z;
    logic [ltip_pkg::STEP_W-1:0]        step_count;

    modport source (output valid, action, first_label, second_label,
                    coord_x, coord_y, coord_z, step_count, input ready);
    modport sink   (input valid, action, first_label, second_label,
                    coord_x, coord_y, coord_z, step_count, output ready);
endinterface

interface ltip_pts_if;
    logic                               valid;
    logic                               ready;
    logic signed [ltip_pkg::COORD_W-1:0] point_x;
    logic signed [ltip_pkg::COORD_W-1:0] point_y;
    logic signed [ltip_pkg::COORD_W-1:0] point_z;
    logic [ltip_pkg::STEP_W-1:0]        point_index;
    logic                               start_found;
    logic                               end_found;
    logic                               last_point;

    modport source (output valid, point_x, point_y, point_z, point_index,
                    start_found, end_found, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, point_index,
                    start_found, end_found, last_point, output ready);
endinterface

[hw/rtl/ltip_table.sv]
// Label point table: one synchronous memory with valid bit, cleared by a sweep after reset.
module ltip_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ltip_pkg::tbl_wr_t            wr,
    input  logic                         rd_en,
    input  logic [ltip_pkg::LABEL_W-1:0] rd_addr,
    output ltip_pkg::entry_t             rd_data,
    output logic                         clearing
);

    ltip_pkg::entry_t mem [ltip_pkg::LABEL_COUNT];

    logic                         clear_reg;
    logic                         clear_next;
    logic [ltip_pkg::LABEL_W-1:0] clr_addr_reg;
    logic [ltip_pkg::LABEL_W-1:0] clr_addr_next;
    ltip_pkg::entry_t             rd_data_reg;

    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ltip_pkg::LABEL_W{1'b1}})
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // single write port: sweep has priority (no commands taken meanwhile)
    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

endmodule

[hw/rtl/ltip_divider.sv]
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
module ltip_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  ltip_pkg::div_req_t req,
    output ltip_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           neg_reg, neg_next;
    logic [ltip_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ltip_pkg::COORD_W-1:0]   work_reg, work_next;
    logic [ltip_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [ltip_pkg::STEP_W-1:0]    dvsr_reg, dvsr_next;
    logic [ltip_pkg::COORD_W:0]     mag;
    logic [ltip_pkg::REM_W-1:0]     trial;
    logic                           fits;

    // |dividend| is below 2^32 for any difference of two 32-bit values
    assign mag   = req.dividend[ltip_pkg::COORD_W] ? (~req.dividend + 1'b1)
                                                   : req.dividend;
    assign trial = {rem_reg[ltip_pkg::REM_W-2:0], work_reg[ltip_pkg::COORD_W-1]};
    assign fits  = (trial >= dvsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.dividend[ltip_pkg::COORD_W];
            cnt_next  = '0;
            work_next = mag[ltip_pkg::COORD_W-1:0];
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (trial - dvsr_reg) : trial;
            work_next = {work_reg[ltip_pkg::COORD_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == {ltip_pkg::DIV_CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~work_reg + 1'b1) : work_reg;

endmodule

[hw/rtl/label_trace_interpolator_top.sv]
// Top level of the label trace interpolator: sequencer, table and divider.
//
// Usage:
//   cmd carries command transactions. action=load writes the point
//   (coord_x, coord_y, coord_z) under first_label. action=trace reads
//   first_label and second_label from the table and emits step_count points
//   (saturated at 64) on pts, each start + i*d with d = (end - start) / N
//   per axis, truncated toward zero. A label never loaded reads as
//   (-1,-1,-1) and clears its found flag. N = 0 gives none.
// Occupancy:
//   A trace occupies the block through accept, the start and end table reads,
//   three serial divisions (one per axis, on the shared divider) and N output
//   points; no new command is taken meanwhile. A load is accepted every cycle
//   while the block is idle and the reset sweep is done.
// Reset:
//   After rst_n the table valid bits are cleared by a sweep over all 1024
//   entries, one per cycle; cmd.ready stays low until the sweep is done.
// Stall:
//   pts has one output register. While it is held by the receiver the
//   trace pauses before emitting its next point; the next command can be
//   accepted once the last point of a trace sits in that register.
module label_trace_interpolator_top (
    input  logic       clk,
    input  logic       rst_n,
    ltip_cmd_if.sink   cmd,
    ltip_pts_if.source pts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_START,
        S_RD_END,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    state_t                        state_reg, state_next;

    // trace context
    logic [ltip_pkg::LABEL_W-1:0]  end_lbl_reg, end_lbl_next;
    logic [ltip_pkg::STEP_W-1:0]   n_reg, n_next;
    logic [ltip_pkg::STEP_W-1:0]   idx_reg, idx_next;
    logic [1:0]                    axis_reg, axis_next;
    logic                          sf_reg, sf_next;
    logic                          ef_reg, ef_next;
    logic [ltip_pkg::COORD_W-1:0]  s_reg [3];
    logic [ltip_pkg::COORD_W-1:0]  s_next [3];
    logic [ltip_pkg::COORD_W-1:0]  e_reg [3];
    logic [ltip_pkg::COORD_W-1:0]  e_next [3];
    logic [ltip_pkg::COORD_W-1:0]  d_reg [3];
    logic [ltip_pkg::COORD_W-1:0]  d_next [3];
    logic [ltip_pkg::COORD_W-1:0]  acc_reg [3];
    logic [ltip_pkg::COORD_W-1:0]  acc_next [3];

    // output register
    logic                          ovalid_reg, ovalid_next;
    logic [ltip_pkg::COORD_W-1:0]  opt_reg [3];
    logic [ltip_pkg::COORD_W-1:0]  opt_next [3];
    logic [ltip_pkg::STEP_W-1:0]   oidx_reg, oidx_next;
    logic                          osf_reg, osf_next;
    logic                          oef_reg, oef_next;
    logic                          olast_reg, olast_next;

    // table and divider hookup
    ltip_pkg::tbl_wr_t             tbl_wr;
    logic                          rd_en;
    logic [ltip_pkg::LABEL_W-1:0]  rd_addr;
    ltip_pkg::entry_t              rd_data;
    logic                          clearing;
    ltip_pkg::div_req_t            div_req;
    ltip_pkg::div_rsp_t            div_rsp;

    logic                          take;
    logic                          is_trace;
    logic [ltip_pkg::STEP_W-1:0]   n_sat;
    logic                          out_free;
    logic [ltip_pkg::COORD_W-1:0]  rd_pt [3];

    ltip_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    ltip_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cmd.ready = (state_reg == S_IDLE) && !clearing;
    assign take      = cmd.valid && cmd.ready;
    assign is_trace  = (cmd.action == ltip_pkg::ACT_TRACE);
    assign n_sat     = (cmd.step_count > ltip_pkg::STEP_W'(ltip_pkg::MAX_STEPS))
                       ? ltip_pkg::STEP_W'(ltip_pkg::MAX_STEPS) : cmd.step_count;
    assign out_free  = !ovalid_reg || pts.ready;

    // loads go straight into the table
    assign tbl_wr.en        = take && !is_trace;
    assign tbl_wr.addr      = cmd.first_label;
    assign tbl_wr.data.valid = 1'b1;
    assign tbl_wr.data.x    = cmd.coord_x;
    assign tbl_wr.data.y    = cmd.coord_y;
    assign tbl_wr.data.z    = cmd.coord_z;

    // start label read at accept, end label read in the cycle after (S_RD_START)
    assign rd_en   = (take && is_trace && (n_sat != '0)) || (state_reg == S_RD_START);
    assign rd_addr = (state_reg == S_RD_START) ? end_lbl_reg : cmd.first_label;

    // invalid entry reads as -1.0 on every axis
    assign rd_pt[0] = rd_data.valid ? rd_data.x : ltip_pkg::MISSING_COORD;
    assign rd_pt[1] = rd_data.valid ? rd_data.y : ltip_pkg::MISSING_COORD;
    assign rd_pt[2] = rd_data.valid ? rd_data.z : ltip_pkg::MISSING_COORD;

    assign div_req.start    = (state_reg == S_DIV_GO);
    assign div_req.dividend = $signed({e_reg[axis_reg][ltip_pkg::COORD_W-1], e_reg[axis_reg]})
                            - $signed({s_reg[axis_reg][ltip_pkg::COORD_W-1], s_reg[axis_reg]});
    assign div_req.divisor  = n_reg;

    always_comb
    begin
        state_next   = state_reg;
        end_lbl_next = end_lbl_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        axis_next    = axis_reg;
        sf_next      = sf_reg;
        ef_next      = ef_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        d_next       = d_reg;
        acc_next     = acc_reg;
        ovalid_next  = ovalid_reg && !pts.ready;
        opt_next     = opt_reg;
        oidx_next    = oidx_reg;
        osf_next     = osf_reg;
        oef_next     = oef_reg;
        olast_next   = olast_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take && is_trace && (n_sat != '0))
                begin
                    end_lbl_next = cmd.second_label;
                    n_next       = n_sat;
                    state_next   = S_RD_START;
                end
            end
            S_RD_START:
            begin
                s_next     = rd_pt;
                acc_next   = rd_pt;
                sf_next    = rd_data.valid;
                state_next = S_RD_END;
            end
            S_RD_END:
            begin
                e_next     = rd_pt;
                ef_next    = rd_data.valid;
                axis_next  = '0;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    d_next[axis_reg] = div_rsp.quotient;
                    if (axis_reg == 2'd2)
                    begin
                        idx_next   = ltip_pkg::STEP_W'(1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    // point i = point (i-1) + d; wraps exactly as s + i*d mod 2^32
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = acc_reg[k] + d_reg[k];
                        opt_next[k] = acc_reg[k] + d_reg[k];
                    end
                    ovalid_next = 1'b1;
                    oidx_next   = idx_reg;
                    osf_next    = sf_reg;
                    oef_next    = ef_reg;
                    olast_next  = (idx_reg == n_reg);
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_lbl_reg <= end_lbl_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        axis_reg    <= axis_next;
        sf_reg      <= sf_next;
        ef_reg      <= ef_next;
        s_reg       <= s_next;
        e_reg       <= e_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        opt_reg     <= opt_next;
        oidx_reg    <= oidx_next;
        osf_reg     <= osf_next;
        oef_reg     <= oef_next;
        olast_reg   <= olast_next;
    end

    assign pts.valid       = ovalid_reg;
    assign pts.point_x     = opt_reg[0];
    assign pts.point_y     = opt_reg[1];
    assign pts.point_z     = opt_reg[2];
    assign pts.point_index = oidx_reg;
    assign pts.start_found = osf_reg;
    assign pts.end_found   = oef_reg;
    assign pts.last_point  = olast_reg;

endmodule
